/* design/mctd_pkg.sv */
package mctd_pkg;

   localparam int NumSensors     = 64;
   localparam int SensorIdxWidth = 6;
   localparam int TimeWidth      = 32;
   localparam int CountWidth     = 7;
   localparam int DebounceWidth  = 16;
   localparam int MaskWidth      = 64;
   localparam int CsrIdxWidth    = 8;
   localparam int CsrDataWidth   = 64;

   localparam logic [DebounceWidth-1:0] DebounceReset = 16'd10;
   localparam logic [CountWidth-1:0]    CountMax      = CountWidth'(NumSensors);

   // register indexes on the csr channel
   localparam logic [CsrIdxWidth-1:0] CsrDebounceMs   = 8'd0;
   localparam logic [CsrIdxWidth-1:0] CsrInputEnable  = 8'd1;

   // transaction modes
   localparam logic ModeSample = 1'b0;
   localparam logic ModeAck    = 1'b1;

   typedef logic [SensorIdxWidth-1:0] sensor_idx_type;

   // per-sensor record held in the store
   typedef struct packed {
      logic                 raw;
      logic                 stable;
      logic                 pending;
      logic [TimeWidth-1:0] stamp;
   } sensor_rec_type;

   // control between the top level and the record store
   typedef struct packed {
      logic           rd_en;
      sensor_idx_type rd_addr;
      logic           wr_en;
      sensor_idx_type wr_addr;
   } store_ctrl_type;

endpackage

/* design/mctd_if.sv */
interface mctd_req_if;
   logic                                valid;
   logic                                ready;
   logic                                mode;
   logic [mctd_pkg::SensorIdxWidth-1:0] sensor_index;
   logic                                pin_level;
   logic [mctd_pkg::TimeWidth-1:0]      now_ms;

   modport source (output valid, mode, sensor_index, pin_level, now_ms, input ready);
   modport sink   (input valid, mode, sensor_index, pin_level, now_ms, output ready);
endinterface

interface mctd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            stable_level;
   logic                            level_accepted;
   logic                            change_pending;
   logic [mctd_pkg::CountWidth-1:0] pending_count;

   modport source (output valid, stable_level, level_accepted, change_pending, pending_count,
                   input ready);
   modport sink   (input valid, stable_level, level_accepted, change_pending, pending_count,
                   output ready);
endinterface

interface mctd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [mctd_pkg::CsrIdxWidth-1:0]  index;
   logic [mctd_pkg::CsrDataWidth-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* design/mctd_rec_store.sv */
module mctd_rec_store (
   input  logic                     clock,
   input  logic                     reset,
   input  mctd_pkg::store_ctrl_type ctrl,
   input  mctd_pkg::sensor_rec_type wr_data,
   output mctd_pkg::sensor_rec_type rd_data
);

   mctd_pkg::sensor_rec_type mem [mctd_pkg::NumSensors];

   logic [mctd_pkg::NumSensors-1:0] vld_ff, vld_in;
   mctd_pkg::sensor_rec_type        rd_data_ff;
   mctd_pkg::sensor_rec_type        fwd_data_ff;
   logic                            rd_vld_ff, rd_vld_in;
   logic                            fwd_hit_ff, fwd_hit_in;

   always_comb begin
      vld_in = vld_ff;
      if (ctrl.wr_en) begin
         vld_in[ctrl.wr_addr] = 1'b1;
      end
   end

   // a write landing on the address being read in the same cycle is forwarded
   assign fwd_hit_in = ctrl.rd_en ? (ctrl.wr_en && (ctrl.wr_addr == ctrl.rd_addr)) : fwd_hit_ff;
   assign rd_vld_in  = ctrl.rd_en ? vld_ff[ctrl.rd_addr] : rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff  <= mem[ctrl.rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         rd_vld_ff  <= rd_vld_in;
         fwd_hit_ff <= fwd_hit_in;
      end
   end

   // entries never written read as the reset record
   assign rd_data = fwd_hit_ff ? fwd_data_ff :
                    (rd_vld_ff ? rd_data_ff : '0);

endmodule

/* design/multi_channel_time_debouncer_unit.sv */
// Channel    | Direction | Carries
// req_chan   | in        | mode, sensor_index, pin_level, now_ms
// rsp_chan   | out       | stable_level, level_accepted, change_pending, pending_count
// csr_chan   | in        | index (0 debounce_ms, 1 input_enable_mask), data
//
// One transaction per cycle sustained while rsp is ready.
// Stage one reads the sensor record from the store; the update and write-back of that
// record and the result register happen on advance, with same-sensor forwarding.
// Synchronous reset: debounce_ms 10, mask 0, all sensor records and pending count zero.
// A stalled rsp holds stage one only when both it and the result register are full.
module multi_channel_time_debouncer_unit (
   input  logic       clock,
   input  logic       reset,
   mctd_req_if.sink   req_chan,
   mctd_rsp_if.source rsp_chan,
   mctd_csr_if.sink   csr_chan
);

   logic [mctd_pkg::DebounceWidth-1:0] debounce_ff, debounce_in;
   logic [mctd_pkg::MaskWidth-1:0]     mask_ff, mask_in;

   logic                               s1_vld_ff, s1_vld_in;
   logic                               s1_mode_ff;
   mctd_pkg::sensor_idx_type           s1_idx_ff;
   logic                               s1_level_ff;
   logic [mctd_pkg::TimeWidth-1:0]     s1_now_ff;

   logic                               out_vld_ff, out_vld_in;
   logic                               out_stable_ff, out_acc_ff, out_pend_ff;
   logic [mctd_pkg::CountWidth-1:0]    out_count_ff;
   logic [mctd_pkg::CountWidth-1:0]    total_ff, total_in;

   logic                               req_take, advance, in_range, enabled, accepted;
   logic [mctd_pkg::TimeWidth-1:0]     elapsed;
   mctd_pkg::store_ctrl_type           store_ctrl;
   mctd_pkg::sensor_rec_type           cur_rec, nxt_rec;

   // configuration
   assign csr_chan.ready = 1'b1;

   always_comb begin
      debounce_in = debounce_ff;
      mask_in     = mask_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            mctd_pkg::CsrDebounceMs:  debounce_in = csr_chan.data[mctd_pkg::DebounceWidth-1:0];
            mctd_pkg::CsrInputEnable: mask_in     = csr_chan.data[mctd_pkg::MaskWidth-1:0];
            default: ;
         endcase
      end
   end

   // handshakes
   assign advance        = s1_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_vld_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign s1_vld_in      = req_take || (s1_vld_ff && !advance);
   assign out_vld_in     = advance || (out_vld_ff && !rsp_chan.ready);

   // record update
   assign in_range = {1'b0, s1_idx_ff} < (mctd_pkg::SensorIdxWidth+1)'(mctd_pkg::NumSensors);
   assign enabled  = mask_ff[s1_idx_ff];
   assign elapsed  = s1_now_ff - cur_rec.stamp;

   always_comb begin
      nxt_rec  = cur_rec;
      total_in = total_ff;
      accepted = 1'b0;
      if (s1_mode_ff == mctd_pkg::ModeAck) begin
         if (cur_rec.pending) begin
            nxt_rec.pending = 1'b0;
            if (total_ff != '0) begin
               total_in = total_ff - 1'b1;
            end
         end
      end else if (enabled) begin
         if (s1_level_ff != cur_rec.raw) begin
            nxt_rec.raw   = s1_level_ff;
            nxt_rec.stamp = s1_now_ff;
         end else if (elapsed > {{(mctd_pkg::TimeWidth-mctd_pkg::DebounceWidth){1'b0}},
                                 debounce_ff}) begin
            if (s1_level_ff != cur_rec.stable) begin
               nxt_rec.stable = s1_level_ff;
               nxt_rec.stamp  = s1_now_ff;
               accepted       = 1'b1;
               if (!cur_rec.pending) begin
                  nxt_rec.pending = 1'b1;
                  if (total_ff < mctd_pkg::CountMax) begin
                     total_in = total_ff + 1'b1;
                  end
               end
            end
         end
      end
      if (!in_range) begin
         nxt_rec  = '0;
         total_in = total_ff;
         accepted = 1'b0;
      end
   end

   assign store_ctrl.rd_en   = req_take;
   assign store_ctrl.rd_addr = req_chan.sensor_index;
   assign store_ctrl.wr_en   = advance && in_range;
   assign store_ctrl.wr_addr = s1_idx_ff;

   mctd_rec_store u_store (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (store_ctrl),
      .wr_data (nxt_rec),
      .rd_data (cur_rec)
   );

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff  <= req_chan.mode;
         s1_idx_ff   <= req_chan.sensor_index;
         s1_level_ff <= req_chan.pin_level;
         s1_now_ff   <= req_chan.now_ms;
      end
      if (advance) begin
         out_stable_ff <= nxt_rec.stable;
         out_acc_ff    <= accepted;
         out_pend_ff   <= nxt_rec.pending;
         out_count_ff  <= total_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= mctd_pkg::DebounceReset;
         mask_ff     <= '0;
         s1_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         total_ff    <= '0;
      end else begin
         debounce_ff <= debounce_in;
         mask_ff     <= mask_in;
         s1_vld_ff   <= s1_vld_in;
         out_vld_ff  <= out_vld_in;
         if (advance) begin
            total_ff <= total_in;
         end
      end
   end

   assign rsp_chan.valid          = out_vld_ff;
   assign rsp_chan.stable_level   = out_stable_ff;
   assign rsp_chan.level_accepted = out_acc_ff;
   assign rsp_chan.change_pending = out_pend_ff;
   assign rsp_chan.pending_count  = out_count_ff;

endmodule

/* design/mctd_checker.sv */
module mctd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_stable_level,
   input logic                            rsp_level_accepted,
   input logic                            rsp_change_pending,
   input logic [mctd_pkg::CountWidth-1:0] rsp_pending_count
);

   // a held transaction keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stable_level)
         && $stable(rsp_level_accepted) && $stable(rsp_change_pending)
         && $stable(rsp_pending_count))
      else $error("rsp payload changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pending_count <= mctd_pkg::CountMax)
      else $error("pending count above sensor count");

   // an accepted level always leaves the sensor pending, so the count is nonzero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_level_accepted |-> rsp_change_pending && (rsp_pending_count != '0))
      else $error("accepted level without pending flag");

endmodule

bind multi_channel_time_debouncer_unit mctd_checker u_mctd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_stable_level   (rsp_chan.stable_level),
   .rsp_level_accepted (rsp_chan.level_accepted),
   .rsp_change_pending (rsp_chan.change_pending),
   .rsp_pending_count  (rsp_chan.pending_count)
);
